FILE: src/vfdm_pkg.sv
`timescale 1ns / 1ps

package vfdm_pkg;

    localparam int LANES      = 4;
    localparam int PIX_W      = 8;
    localparam int COEFF_W    = 16;
    localparam int USED_W     = 3;
    localparam int ACC_W      = 32;
    // pixel is zero-extended to 9 bits, so the product needs 9 + 16 bits
    localparam int PROD_W     = PIX_W + 1 + COEFF_W;
    localparam int FRAC_SHIFT = 12;

    localparam logic [ACC_W-1:0] ROUND_CONST = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [PIX_W-1:0] PIX_MAX     = {PIX_W{1'b1}};

    typedef logic [LANES-1:0][PIX_W-1:0] lane_bytes_t;

    // control word carried alongside the per-lane product registers
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [USED_W-1:0] used;
    } tap_ctrl_t;

endpackage

FILE: src/vfdm_lane.sv
`timescale 1ns / 1ps

module vfdm_lane
#(
    parameter int FRAC_SHIFT = vfdm_pkg::FRAC_SHIFT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 step,
    input  logic                                 last,
    input  logic [vfdm_pkg::PIX_W-1:0]           pixel,
    input  logic signed [vfdm_pkg::COEFF_W-1:0]  coeff,
    output logic [vfdm_pkg::PIX_W-1:0]           result
);

    // half of one output step
    localparam logic [vfdm_pkg::ACC_W-1:0] ROUND_VAL =
        vfdm_pkg::ACC_W'(1) << (FRAC_SHIFT - 1);

    logic signed [vfdm_pkg::PROD_W-1:0] prod_reg;
    logic signed [vfdm_pkg::PROD_W-1:0] prod_next;
    logic [vfdm_pkg::ACC_W-1:0]         acc_reg;
    logic [vfdm_pkg::ACC_W-1:0]         acc_next;
    logic [vfdm_pkg::ACC_W-1:0]         sum;
    logic [vfdm_pkg::ACC_W-1:0]         shifted;

    assign prod_next = $signed({1'b0, pixel}) * coeff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // wraps modulo 2^32
    assign sum = acc_reg + vfdm_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (step)
        begin
            acc_next = last ? ROUND_VAL : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= ROUND_VAL;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // logical shift then clamp to a byte
    assign shifted = sum >> FRAC_SHIFT;

    always_comb
    begin
        if (sum[vfdm_pkg::ACC_W-1])
        begin
            result = '0;
        end
        else if (|shifted[vfdm_pkg::ACC_W-1:vfdm_pkg::PIX_W])
        begin
            result = vfdm_pkg::PIX_MAX;
        end
        else
        begin
            result = shifted[vfdm_pkg::PIX_W-1:0];
        end
    end

endmodule

FILE: src/vfdm_merge.sv
`timescale 1ns / 1ps

module vfdm_merge
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  vfdm_pkg::tap_ctrl_t               ctrl,
    input  vfdm_pkg::lane_bytes_t             lane_bytes,
    output logic                              out_valid,
    output vfdm_pkg::lane_bytes_t             out_bytes
);

    logic                  valid_reg;
    logic                  valid_next;
    vfdm_pkg::lane_bytes_t bytes_reg;
    vfdm_pkg::lane_bytes_t bytes_next;

    // lanes at or past lanes_used read as zero
    always_comb
    begin
        for (int i = 0; i < vfdm_pkg::LANES; i++)
        begin
            bytes_next[i] = (ctrl.used > vfdm_pkg::USED_W'(i)) ? lane_bytes[i] : '0;
        end
    end

    assign valid_next = advance ? (ctrl.valid && ctrl.last) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.valid && ctrl.last)
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bytes = bytes_reg;

endmodule

FILE: src/vertical_fir_downscale_mac_core.sv
`timescale 1ns / 1ps

// Channel   Handshake              Word
// in        in_valid / in_stall    pixel_0..pixel_3, coeff, last_tap, lanes_used
// out       out_valid / out_stall  result_0..result_3
//
// One tap word per cycle unless out_stall holds the pipe, a rate set by the
// single 9x16 multiplier per lane feeding a registered 32-bit accumulate; a
// result word passes the product stage and output register after its last tap.
// Reset clears valid flags and loads each accumulator with the rounding value.
// A stalled result holds the whole pipe; in_stall follows out_stall while a
// result is waiting in the output register.

module vertical_fir_downscale_mac_core
#(
    parameter int FRAC_SHIFT = vfdm_pkg::FRAC_SHIFT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vfdm_pkg::PIX_W-1:0]           pixel_0,
    input  logic [vfdm_pkg::PIX_W-1:0]           pixel_1,
    input  logic [vfdm_pkg::PIX_W-1:0]           pixel_2,
    input  logic [vfdm_pkg::PIX_W-1:0]           pixel_3,
    input  logic signed [vfdm_pkg::COEFF_W-1:0]  coeff,
    input  logic                                 last_tap,
    input  logic [vfdm_pkg::USED_W-1:0]          lanes_used,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vfdm_pkg::PIX_W-1:0]           result_0,
    output logic [vfdm_pkg::PIX_W-1:0]           result_1,
    output logic [vfdm_pkg::PIX_W-1:0]           result_2,
    output logic [vfdm_pkg::PIX_W-1:0]           result_3
);

    logic                                       advance;
    logic                                       in_take;
    logic                                       step;
    vfdm_pkg::tap_ctrl_t                        ctrl_reg;
    vfdm_pkg::tap_ctrl_t                        ctrl_next;
    logic [vfdm_pkg::LANES-1:0][vfdm_pkg::PIX_W-1:0] pixels;
    vfdm_pkg::lane_bytes_t                      lane_bytes;
    vfdm_pkg::lane_bytes_t                      out_bytes;

    // pipe moves whenever the output register is empty or being drained
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign in_take  = in_valid && advance;
    // product stage holds a tap that is folded into the accumulators this cycle
    assign step     = ctrl_reg.valid && advance;

    assign pixels = {pixel_3, pixel_2, pixel_1, pixel_0};

    always_comb
    begin
        ctrl_next = ctrl_reg;
        if (advance)
        begin
            ctrl_next.valid = in_valid;
            ctrl_next.last  = last_tap;
            ctrl_next.used  = lanes_used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // one multiply-accumulate lane per column
    for (genvar g = 0; g < vfdm_pkg::LANES; g++)
    begin : g_lane
        vfdm_lane
        #(
            .FRAC_SHIFT (FRAC_SHIFT)
        )
        u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (in_take),
            .step   (step),
            .last   (ctrl_reg.last),
            .pixel  (pixels[g]),
            .coeff  (coeff),
            .result (lane_bytes[g])
        );
    end

    // masks unused lanes and holds the result word
    vfdm_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl       (ctrl_reg),
        .lane_bytes (lane_bytes),
        .out_valid  (out_valid),
        .out_bytes  (out_bytes)
    );

    assign result_0 = out_bytes[0];
    assign result_1 = out_bytes[1];
    assign result_2 = out_bytes[2];
    assign result_3 = out_bytes[3];

    // a taken tap always lands in the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ctrl_reg.valid)
        else $error("accepted tap lost before product stage");

    // a last tap that moves on must produce a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.valid && ctrl_reg.last && advance |=> out_valid)
        else $error("last tap gave no result");

    // a drained result is not repeated without a fresh last tap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(ctrl_reg.valid && ctrl_reg.last) |=> !out_valid)
        else $error("result word repeated");

endmodule
